// ----- design/lis_pkg.sv -----
package lis_pkg;

    // Capacity and element width
    localparam int MAX_LEN     = 1024;
    localparam int VALUE_WIDTH = 32;

    // Internal widths that follow from the capacity
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = IDX_W + 1;

    // Fixed port widths
    localparam int IN_VALUE_W = 32;
    localparam int INDEX_W    = 10;
    localparam int LEN_W      = 11;
    localparam int PRED_W     = 11;

    // Sign-bit flip maps signed order onto unsigned order
    localparam logic [VALUE_WIDTH-1:0] KEY_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Request held in the queue between front and back
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] key;
        logic                   last;
    } item_t;

    // Scan engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- design/lis_front.sv -----
module lis_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic signed [lis_pkg::IN_VALUE_W-1:0]  s_value,
    input  logic                                   s_last,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    output logic                                   q_valid,
    input  logic                                   q_pop,
    output lis_pkg::item_t                         q_item
);

    lis_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    logic           pop;
    lis_pkg::item_t in_item;

    // Classify the incoming request: turn the signed value into an ordered key
    always_comb begin
        in_item.key  = s_value[lis_pkg::VALUE_WIDTH-1:0] ^ lis_pkg::KEY_SIGN;
        in_item.last = s_last;
    end

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- design/lis_back.sv -----
module lis_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  lis_pkg::item_t                       q_item,
    output logic [lis_pkg::INDEX_W-1:0]          m_index,
    output logic [lis_pkg::LEN_W-1:0]            m_length_here,
    output logic signed [lis_pkg::PRED_W-1:0]    m_predecessor,
    output logic [lis_pkg::LEN_W-1:0]            m_best_length,
    output logic [lis_pkg::INDEX_W-1:0]          m_best_end,
    output logic                                 m_overflow,
    output logic                                 m_done_res,
    output logic                                 m_valid,
    input  logic                                 m_ready
);

    localparam int IDX_W = lis_pkg::IDX_W;
    localparam int CNT_W = lis_pkg::CNT_W;
    localparam int VW    = lis_pkg::VALUE_WIDTH;

    // Element store
    logic [VW-1:0]    val_mem [lis_pkg::MAX_LEN];
    logic [CNT_W-1:0] len_mem [lis_pkg::MAX_LEN];
    logic [VW-1:0]    rd_val_reg;
    logic [CNT_W-1:0] rd_len_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_en;
    logic             wr_en;

    lis_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] best_len_reg, best_len_next;
    logic [IDX_W-1:0] best_end_reg, best_end_next;
    logic [CNT_W-1:0] addr_reg, addr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0] prev_len_reg, prev_len_next;
    logic [IDX_W-1:0] pj_reg, pj_next;
    logic             have_reg, have_next;
    logic [VW-1:0]    key_reg;
    logic             last_reg;

    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             load_out;
    logic [lis_pkg::INDEX_W-1:0] o_index_reg, o_index_next;
    logic [lis_pkg::LEN_W-1:0]   o_len_reg, o_len_next;
    logic [lis_pkg::PRED_W-1:0]  o_pred_reg, o_pred_next;
    logic [lis_pkg::LEN_W-1:0]   o_best_len_reg, o_best_len_next;
    logic [lis_pkg::INDEX_W-1:0] o_best_end_reg, o_best_end_next;
    logic                        o_ovf_reg, o_ovf_next;
    logic                        o_done_reg, o_done_next;

    logic [CNT_W-1:0] new_len;
    logic [CNT_W-1:0] upd_len;
    logic [IDX_W-1:0] upd_end;
    logic [IDX_W-1:0] cur_idx;

    assign out_free = !out_valid_reg || m_ready;
    assign cur_idx  = count_reg[IDX_W-1:0];
    assign new_len  = prev_len_reg + CNT_W'(1);

    // Next state, scan control and result forming
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        best_len_next   = best_len_reg;
        best_end_next   = best_end_reg;
        addr_next       = addr_reg;
        rd_vld_next     = 1'b0;
        prev_len_next   = prev_len_reg;
        pj_next         = pj_reg;
        have_next       = have_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        load_out        = 1'b0;
        upd_len         = best_len_reg;
        upd_end         = best_end_reg;
        o_index_next    = '0;
        o_len_next      = '0;
        o_pred_next     = '1;
        o_best_len_next = lis_pkg::LEN_W'(best_len_reg);
        o_best_end_next = lis_pkg::INDEX_W'(best_end_reg);
        o_ovf_next      = 1'b0;
        o_done_next     = last_reg;

        // Fold in the entry read last cycle; first maximum wins
        if (rd_vld_reg && (rd_val_reg < key_reg) && (rd_len_reg > prev_len_reg)) begin
            prev_len_next = rd_len_reg;
            pj_next       = rd_idx_reg;
            have_next     = 1'b1;
        end

        case (state_reg)
            lis_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (count_reg == CNT_W'(lis_pkg::MAX_LEN)) begin
                        // Capacity reached: report without storing
                        if (out_free) begin
                            q_pop       = 1'b1;
                            load_out    = 1'b1;
                            o_ovf_next  = 1'b1;
                            o_done_next = q_item.last;
                            if (q_item.last) begin
                                count_next    = '0;
                                best_len_next = '0;
                                best_end_next = '0;
                            end
                        end
                    end else begin
                        q_pop         = 1'b1;
                        addr_next     = '0;
                        prev_len_next = '0;
                        pj_next       = '0;
                        have_next     = 1'b0;
                        state_next    = lis_pkg::ST_SCAN;
                    end
                end
            end
            lis_pkg::ST_SCAN: begin
                if (addr_reg != count_reg) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    addr_next   = addr_reg + CNT_W'(1);
                end else if (!rd_vld_reg) begin
                    state_next = lis_pkg::ST_FINISH;
                end
            end
            lis_pkg::ST_FINISH: begin
                if (out_free) begin
                    wr_en    = 1'b1;
                    load_out = 1'b1;
                    if (new_len > best_len_reg) begin
                        upd_len = new_len;
                        upd_end = cur_idx;
                    end
                    o_index_next    = lis_pkg::INDEX_W'(cur_idx);
                    o_len_next      = lis_pkg::LEN_W'(new_len);
                    o_pred_next     = have_reg ? lis_pkg::PRED_W'(pj_reg) : '1;
                    o_best_len_next = lis_pkg::LEN_W'(upd_len);
                    o_best_end_next = lis_pkg::INDEX_W'(upd_end);
                    if (last_reg) begin
                        count_next    = '0;
                        best_len_next = '0;
                        best_end_next = '0;
                    end else begin
                        count_next    = count_reg + CNT_W'(1);
                        best_len_next = upd_len;
                        best_end_next = upd_end;
                    end
                    state_next = lis_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lis_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !m_ready);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lis_pkg::ST_IDLE;
            count_reg     <= '0;
            best_len_reg  <= '0;
            best_end_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            best_len_reg  <= best_len_next;
            best_end_reg  <= best_end_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan datapath and captured request
    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        prev_len_reg <= prev_len_next;
        pj_reg       <= pj_next;
        have_reg     <= have_next;
        if (q_pop) begin
            key_reg  <= q_item.key;
            last_reg <= q_item.last;
        end
        if (rd_en) begin
            rd_idx_reg <= addr_reg[IDX_W-1:0];
        end
    end

    // Value store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            val_mem[cur_idx] <= key_reg;
        end
        if (rd_en) begin
            rd_val_reg <= val_mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Length store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            len_mem[cur_idx] <= new_len;
        end
        if (rd_en) begin
            rd_len_reg <= len_mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            o_index_reg    <= o_index_next;
            o_len_reg      <= o_len_next;
            o_pred_reg     <= o_pred_next;
            o_best_len_reg <= o_best_len_next;
            o_best_end_reg <= o_best_end_next;
            o_ovf_reg      <= o_ovf_next;
            o_done_reg     <= o_done_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_index       = o_index_reg;
    assign m_length_here = o_len_reg;
    assign m_predecessor = o_pred_reg;
    assign m_best_length = o_best_len_reg;
    assign m_best_end    = o_best_end_reg;
    assign m_overflow    = o_ovf_reg;
    assign m_done_res    = o_done_reg;

endmodule

// ----- design/longest_increasing_subsequence_core.sv -----
// Each element is compared against every earlier stored element of its sequence
// before its result is loaded; an overflowed one is reported without a scan.
// Elements are handled one at a time, limited by the single read port of the
// element store scanned one entry per cycle.
// Reset (aresetn low, synchronous) empties the queue, drops any result and
// starts a fresh sequence; the element store needs no clearing.
module longest_increasing_subsequence_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [lis_pkg::IN_VALUE_W-1:0] s_value,
    input  logic                                 s_last,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    output logic [lis_pkg::INDEX_W-1:0]          m_index,
    output logic [lis_pkg::LEN_W-1:0]            m_length_here,
    output logic signed [lis_pkg::PRED_W-1:0]    m_predecessor,
    output logic [lis_pkg::LEN_W-1:0]            m_best_length,
    output logic [lis_pkg::INDEX_W-1:0]          m_best_end,
    output logic                                 m_overflow,
    output logic                                 m_done_res,
    output logic                                 m_valid,
    input  logic                                 m_ready
);

    logic           q_valid;
    logic           q_pop;
    lis_pkg::item_t q_item;

    lis_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_value (s_value),
        .s_last  (s_last),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    lis_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .m_index       (m_index),
        .m_length_here (m_length_here),
        .m_predecessor (m_predecessor),
        .m_best_length (m_best_length),
        .m_best_end    (m_best_end),
        .m_overflow    (m_overflow),
        .m_done_res    (m_done_res),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    // Overflowed results, and only those, carry a zero length
    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_overflow == (m_length_here == '0)))
        else $error("overflow flag and length disagree");

    // A stored element never beats the running best
    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_overflow) |-> (m_length_here <= m_best_length))
        else $error("element length exceeds best length");

    // A predecessor always lies before the element
    a_pred_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_predecessor[lis_pkg::PRED_W-1])
            |-> (m_predecessor[lis_pkg::INDEX_W-1:0] < m_index))
        else $error("predecessor not before element");

    // A queued request is never taken while the queue is empty
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ----- test/longest_increasing_subsequence_core_tb.sv -----
module longest_increasing_subsequence_core_tb;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [lis_pkg::IN_VALUE_W-1:0] VALUE_MIN =
        {1'b1, {(lis_pkg::IN_VALUE_W-1){1'b0}}};
    localparam logic signed [lis_pkg::IN_VALUE_W-1:0] VALUE_MAX =
        {1'b0, {(lis_pkg::IN_VALUE_W-1){1'b1}}};

    // Shapes of random sequence content
    typedef enum int {
        SEQ_SCATTERED,
        SEQ_CLUSTERED,
        SEQ_RISING,
        SEQ_FALLING,
        SEQ_EXTREMES
    } seq_shape_t;

    // One result of the block, as predicted or as observed
    typedef struct packed {
        logic [lis_pkg::INDEX_W-1:0]       index;
        logic [lis_pkg::LEN_W-1:0]         length_here;
        logic signed [lis_pkg::PRED_W-1:0] predecessor;
        logic [lis_pkg::LEN_W-1:0]         best_length;
        logic [lis_pkg::INDEX_W-1:0]       best_end;
        logic                              overflow;
        logic                              done_res;
    } lis_result_t;

    logic                                   aclk;
    logic                                   aresetn;
    logic signed [lis_pkg::IN_VALUE_W-1:0]  s_value;
    logic                                   s_last;
    logic                                   s_valid;
    logic                                   s_ready;
    logic [lis_pkg::INDEX_W-1:0]            m_index;
    logic [lis_pkg::LEN_W-1:0]              m_length_here;
    logic signed [lis_pkg::PRED_W-1:0]      m_predecessor;
    logic [lis_pkg::LEN_W-1:0]              m_best_length;
    logic [lis_pkg::INDEX_W-1:0]            m_best_end;
    logic                                   m_overflow;
    logic                                   m_done_res;
    logic                                   m_valid;
    logic                                   m_ready;

    // Predictor copy of the sequence store and running best
    logic signed [lis_pkg::IN_VALUE_W-1:0]  seq_values [lis_pkg::MAX_LEN];
    logic [lis_pkg::LEN_W-1:0]              seq_lengths [lis_pkg::MAX_LEN];
    int unsigned                            seq_count;
    logic [lis_pkg::LEN_W-1:0]              run_best_len;
    logic [lis_pkg::INDEX_W-1:0]            run_best_end;

    lis_result_t                            pending_results [$];
    int                                     fail_count;
    int                                     send_idle_pct;
    int                                     recv_idle_pct;
    logic                                   rx_hold = 1'b0;

    longest_increasing_subsequence_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_value       (s_value),
        .s_last        (s_last),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_index       (m_index),
        .m_length_here (m_length_here),
        .m_predecessor (m_predecessor),
        .m_best_length (m_best_length),
        .m_best_end    (m_best_end),
        .m_overflow    (m_overflow),
        .m_done_res    (m_done_res),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // End the run if it hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Extend the LIS of the current sequence by one element
    function automatic lis_result_t lis_extend(
        input logic signed [lis_pkg::IN_VALUE_W-1:0] v,
        input logic l);
        lis_result_t r;
        logic [lis_pkg::LEN_W-1:0] prev_len;
        int pj;
        r = '0;
        r.predecessor = '1;
        if (seq_count < lis_pkg::MAX_LEN) begin
            prev_len = '0;
            pj = -1;
            // take the earliest smaller element with the greatest length
            for (int j = 0; j < seq_count; j++) begin
                if (seq_values[j] < v && seq_lengths[j] > prev_len) begin
                    prev_len = seq_lengths[j];
                    pj = j;
                end
            end
            seq_values[seq_count] = v;
            seq_lengths[seq_count] = prev_len + 1'b1;
            if (seq_lengths[seq_count] > run_best_len) begin
                run_best_len = seq_lengths[seq_count];
                run_best_end = lis_pkg::INDEX_W'(seq_count);
            end
            r.index = lis_pkg::INDEX_W'(seq_count);
            r.length_here = seq_lengths[seq_count];
            if (pj >= 0)
                r.predecessor = lis_pkg::PRED_W'(pj);
            seq_count++;
        end else begin
            r.overflow = 1'b1;
        end
        r.best_length = run_best_len;
        r.best_end = run_best_end;
        r.done_res = l;
        // close the sequence
        if (l) begin
            seq_count = 0;
            run_best_len = '0;
            run_best_end = '0;
        end
        return r;
    endfunction

    // Offer one request and record its expected result once accepted
    task automatic send_element(input logic signed [lis_pkg::IN_VALUE_W-1:0] v,
                                input logic l);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(lis_extend(v, l));
    endtask

    // Stop offering and wait for every expected result
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [lis_pkg::IN_VALUE_W-1:0] pick_value(
        input seq_shape_t shape,
        input int pos);
        logic signed [lis_pkg::IN_VALUE_W-1:0] v;
        case (shape)
            SEQ_SCATTERED: v = $urandom;
            SEQ_CLUSTERED: v = $signed($urandom_range(15)) - 8;
            SEQ_RISING:    v = pos * 4 + $signed($urandom_range(12)) - 6;
            SEQ_FALLING:   v = -pos * 4 + $signed($urandom_range(12)) - 6;
            default: begin
                case ($urandom_range(4))
                    0:       v = VALUE_MIN;
                    1:       v = VALUE_MAX;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // Check each accepted result against the oldest expectation; drive ready
    always @(posedge aclk) begin
        lis_result_t got;
        lis_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_index, m_length_here, m_predecessor, m_best_length, m_best_end,
                    m_overflow, m_done_res};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("tb: result with none expected: idx=%0d len=%0d pred=%0d",
                             got.index, got.length_here, got.predecessor);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        // fields: index, length, predecessor, best, end, overflow, last
                        $display("tb: mismatch expected %0d %0d %0d %0d %0d %0b %0b",
                                 want.index, want.length_here, want.predecessor,
                                 want.best_length, want.best_end, want.overflow,
                                 want.done_res);
                        $display("tb:          got      %0d %0d %0d %0d %0d %0b %0b",
                                 got.index, got.length_here, got.predecessor,
                                 got.best_length, got.best_end, got.overflow,
                                 got.done_res);
                    end
                end
            end
        end
        // hold off while a counted stretch runs, else idle at random
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Extreme values, including a repeat of the minimum that must not extend
    task automatic test_value_extremes();
        send_element(VALUE_MIN, 1'b0);
        send_element(VALUE_MAX, 1'b0);
        send_element(0, 1'b0);
        send_element(-1, 1'b0);
        send_element(VALUE_MIN, 1'b0);
        send_element(VALUE_MIN + 1, 1'b0);
        send_element(VALUE_MAX, 1'b1);
    endtask

    // One-element sequences back to back
    task automatic test_single_element();
        send_element(VALUE_MAX, 1'b1);
        send_element(VALUE_MIN, 1'b1);
    endtask

    // Equal values, earliest predecessor on a tie, first best end kept
    task automatic test_ties_and_equal_values();
        send_element(5, 1'b0);
        send_element(3, 1'b0);
        send_element(5, 1'b0);
        send_element(3, 1'b0);
        send_element(4, 1'b0);
        send_element(6, 1'b0);
        send_element(0, 1'b0);
        send_element(1, 1'b0);
        send_element(2, 1'b0);
        send_element(2, 1'b1);
        send_element(1, 1'b0);
        send_element(0, 1'b1);
    endtask

    task automatic test_random_sequences(input int target);
        int sent;
        int len;
        seq_shape_t shape;
        sent = 0;
        while (sent < target) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
            shape = seq_shape_t'($urandom_range(4));
            for (int k = 0; k < len; k++)
                send_element(pick_value(shape, k), k == len - 1);
            sent += len;
        end
        drain_results();
    endtask

    // Stall the result side long enough for the input to back up
    task automatic test_output_backpressure();
        // count the hold-off stretch in its own process
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        for (int k = 0; k < 48; k++)
            send_element(pick_value(SEQ_CLUSTERED, k), k == 47);
        drain_results();
    endtask

    // Fill the store, overflow twice with the last flag on the second, restart
    task automatic test_capacity_overflow();
        for (int k = 0; k < lis_pkg::MAX_LEN + 2; k++)
            send_element($urandom, k == lis_pkg::MAX_LEN + 1);
        send_element(7, 1'b0);
        send_element(8, 1'b1);
        drain_results();
    endtask

    initial begin
        seq_count = 0;
        run_best_len = '0;
        run_best_end = '0;
        send_idle_pct = 30;
        recv_idle_pct = 72;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        s_last  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_value_extremes();
        test_single_element();
        test_ties_and_equal_values();
        drain_results();
        test_random_sequences(195);

        send_idle_pct = 72;
        recv_idle_pct = 30;
        test_random_sequences(195);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(190);
        test_capacity_overflow();

        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
